[rtl/pcbdl_pkg.sv]
// Shared types and constants of the per-client byte debt limiter.
// No dependencies.
package pcbdl_pkg;

  localparam int unsigned ClientSlots = 256;
  localparam int unsigned SlotW       = $clog2(ClientSlots);
  localparam int unsigned WordW       = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegNormalRate   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegModRate      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNormalMax    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegModMax       = 2'd3;

  // command codes
  localparam logic CmdCheck  = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  // one classified item handed from front to back
  typedef struct packed {
    logic             command;
    logic [SlotW-1:0] slot;
    logic [WordW-1:0] rate;
    logic [WordW-1:0] limit;
    logic [WordW-1:0] now;
    logic [WordW-1:0] bytes;
  } job_t;

endpackage

[rtl/per_client_byte_debt_limiter_unit.sv]
// Per-client byte debt limiter top level: registers, front end and back end.
// Depends on pcbdl_pkg, pcbdl_front, pcbdl_back.
// A check returns one result beat with the drained debt, a blocked flag and
// the wait time; an update returns none. An update goes through read,
// multiply, drain and write in the back end; a check then gives its result
// beat, and a blocked check at nonzero rate first runs the serial 32-bit
// divider (one quotient bit per cycle). The result beat can be stalled.
// A two-entry queue lets items be taken while the back end is busy. The
// client valid bits clear at reset.
module per_client_byte_debt_limiter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  client_index_i,
  input  logic        is_moderator_i,
  input  logic [31:0] now_seconds_i,
  input  logic [31:0] byte_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        blocked_o,
  output logic [31:0] wait_seconds_o,
  output logic [31:0] current_debt_o
);

  logic [31:0]     nrate_q, mrate_q, nmax_q, mmax_q;
  logic            job_valid, job_ready;
  pcbdl_pkg::job_t job;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrate_q <= 32'd1;
      mrate_q <= 32'd1;
      nmax_q  <= '0;
      mmax_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pcbdl_pkg::RegNormalRate: nrate_q <= cfg_data_i;
        pcbdl_pkg::RegModRate:    mrate_q <= cfg_data_i;
        pcbdl_pkg::RegNormalMax:  nmax_q  <= cfg_data_i;
        pcbdl_pkg::RegModMax:     mmax_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcbdl_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .client_index_i,
    .is_moderator_i, .now_seconds_i, .byte_count_i,
    .normal_rate_i    (nrate_q),
    .moderator_rate_i (mrate_q),
    .normal_max_i     (nmax_q),
    .moderator_max_i  (mmax_q),
    .job_valid_o      (job_valid),
    .job_ready_i      (job_ready),
    .job_o            (job)
  );

  pcbdl_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o, .out_ready_i, .blocked_o, .wait_seconds_o, .current_debt_o
  );

endmodule

[rtl/pcbdl_front.sv]
// Front end: accepts items, picks rate and limit, queues jobs for the back end.
// Depends on pcbdl_pkg.
module pcbdl_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [7:0]                  client_index_i,
  input  logic                        is_moderator_i,
  input  logic [pcbdl_pkg::WordW-1:0] now_seconds_i,
  input  logic [pcbdl_pkg::WordW-1:0] byte_count_i,
  input  logic [pcbdl_pkg::WordW-1:0] normal_rate_i,
  input  logic [pcbdl_pkg::WordW-1:0] moderator_rate_i,
  input  logic [pcbdl_pkg::WordW-1:0] normal_max_i,
  input  logic [pcbdl_pkg::WordW-1:0] moderator_max_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output pcbdl_pkg::job_t             job_o
);

  pcbdl_pkg::job_t                  fifo_q [pcbdl_pkg::QueueDepth];
  logic [pcbdl_pkg::QueuePtrW-1:0]  wr_q, rd_q;
  logic [pcbdl_pkg::QueuePtrW:0]    cnt_q;
  pcbdl_pkg::job_t                  job_new;
  logic                             push, pop;

  // classify the incoming item
  always_comb begin
    job_new.command = command_i;
    job_new.slot    = client_index_i[pcbdl_pkg::SlotW-1:0];
    job_new.rate    = is_moderator_i ? moderator_rate_i : normal_rate_i;
    job_new.limit   = is_moderator_i ? moderator_max_i : normal_max_i;
    job_new.now     = now_seconds_i;
    job_new.bytes   = byte_count_i;
  end

  assign in_ready_o  = (cnt_q != (pcbdl_pkg::QueuePtrW+1)'(pcbdl_pkg::QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign job_valid_o = (cnt_q != '0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = fifo_q[rd_q];

  // store queued jobs
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= job_new;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[rtl/pcbdl_divider.sv]
// Serial restoring divider: one quotient bit per cycle.
// Depends on pcbdl_pkg.
module pcbdl_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pcbdl_pkg::WordW-1:0] dividend_i,
  input  logic [pcbdl_pkg::WordW-1:0] divisor_i,
  output logic                        done_o,
  output logic [pcbdl_pkg::WordW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(pcbdl_pkg::WordW + 1);

  logic [pcbdl_pkg::WordW-1:0] quo_q, dsr_q;
  logic [pcbdl_pkg::WordW:0]   rem_q, rem_sh;
  logic [CntW-1:0]             cnt_q;
  logic                        busy_q;

  assign rem_sh     = {rem_q[pcbdl_pkg::WordW-1:0], quo_q[pcbdl_pkg::WordW-1]};
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

  // shift in one bit and subtract when it fits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(pcbdl_pkg::WordW);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_q <= rem_sh - {1'b0, dsr_q};
        quo_q <= {quo_q[pcbdl_pkg::WordW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[pcbdl_pkg::WordW-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/pcbdl_back.sv]
// Back end: client table, drain, update and blocked check with serial wait divide.
// Depends on pcbdl_pkg and pcbdl_divider.
module pcbdl_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  pcbdl_pkg::job_t             job_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        blocked_o,
  output logic [pcbdl_pkg::WordW-1:0] wait_seconds_o,
  output logic [pcbdl_pkg::WordW-1:0] current_debt_o
);

  localparam int unsigned W = pcbdl_pkg::WordW;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StMul   = 7'b0000100,
    StSub   = 7'b0001000,
    StDrain = 7'b0010000,
    StDiv   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  pcbdl_pkg::job_t         job_q;
  logic [pcbdl_pkg::ClientSlots-1:0] valid_q;
  logic [W-1:0]            debt_mem [pcbdl_pkg::ClientSlots];
  logic [W-1:0]            stamp_mem [pcbdl_pkg::ClientSlots];
  logic [W-1:0]            rd_debt_q, rd_stamp_q;
  logic                    rd_valid_q;
  logic [2*W-1:0]          leak_q;
  logic [W-1:0]            debt_q, elapsed;
  logic [W-1:0]            drained;
  logic [W:0]              sum;
  logic                    div_start, div_done;
  logic [W-1:0]            quo;
  logic                    out_valid_q, blocked_q;
  logic [W-1:0]            wait_q, cur_q;
  logic                    is_block;

  assign job_ready_o = (state_q == StIdle);
  assign elapsed = (job_q.now > rd_stamp_q) ? job_q.now - rd_stamp_q : '0;
  assign drained = (!rd_valid_q || leak_q >= {{W{1'b0}}, rd_debt_q}) ? '0
                 : W'({{W{1'b0}}, rd_debt_q} - leak_q);
  assign sum      = {1'b0, debt_q} + {1'b0, job_q.bytes};
  assign is_block = !(debt_q < job_q.limit);
  assign div_start = (state_q == StDrain) && (job_q.command == pcbdl_pkg::CmdCheck)
                   && is_block && (job_q.rate != '0);

  pcbdl_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (debt_q - job_q.limit),
    .divisor_i  (job_q.rate),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // sequence one job
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (job_valid_i) state_d = StRead;
      StRead:  state_d = StMul;
      StMul:   state_d = StSub;
      StSub:   state_d = StDrain;
      StDrain: begin
        if (job_q.command == pcbdl_pkg::CmdUpdate) state_d = StIdle;
        else if (div_start) state_d = StDiv;
        else state_d = StOut;
      end
      StDiv:   if (div_done) state_d = StOut;
      StOut:   if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // table and datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: job_q <= job_i;
      StRead: begin
        rd_debt_q  <= debt_mem[job_q.slot];
        rd_stamp_q <= stamp_mem[job_q.slot];
      end
      StMul:   leak_q <= elapsed * job_q.rate;
      StDrain: begin
        if (job_q.command == pcbdl_pkg::CmdUpdate) begin
          debt_mem[job_q.slot]  <= sum[W] ? {W{1'b1}} : sum[W-1:0];
          stamp_mem[job_q.slot] <= job_q.now;
        end
      end
      StSub, StDiv, StOut: ;
      default: ;
    endcase
    if (state_q == StSub) debt_q <= drained;
  end

  // advance state, set valid bits and run the result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StRead) rd_valid_q <= valid_q[job_q.slot];
      if (state_q == StDrain && job_q.command == pcbdl_pkg::CmdUpdate)
        valid_q[job_q.slot] <= 1'b1;
      if (state_q == StOut && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && (!out_valid_q || out_ready_i)) begin
      blocked_q <= is_block;
      cur_q     <= debt_q;
      if (!is_block) wait_q <= '0;
      else if (job_q.rate == '0) wait_q <= {W{1'b1}};
      else wait_q <= (quo == {W{1'b1}}) ? quo : quo + 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blocked_o      = blocked_q;
  assign wait_seconds_o = wait_q;
  assign current_debt_o = cur_q;

endmodule
